// ===== hdl/imts_pkg.sv =====
// Package for the I2C master transaction sequencer.
// Holds the request and response structs, the descriptor layout and the codes.
// Depends on nothing; the top level uses it by scoped names.
package imts_pkg;

    // Width of the transfer length fields and of the byte position counter.
    localparam int LEN_W = 5;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_SUBMIT = 2'd1,
        REQ_EVENT  = 2'd2
    } req_kind_t;

    // Transaction kinds.
    typedef enum logic [1:0] {
        KIND_WRITE      = 2'd0,
        KIND_READ       = 2'd1,
        KIND_WRITE_READ = 2'd2
    } trans_kind_t;

    // Controller status events, densely numbered.
    typedef enum logic [3:0] {
        EV_START        = 4'd0,
        EV_RESTART      = 4'd1,
        EV_MT_SLA_ACK   = 4'd2,
        EV_MT_SLA_NACK  = 4'd3,
        EV_MT_DATA_ACK  = 4'd4,
        EV_MR_SLA_ACK   = 4'd5,
        EV_MR_SLA_NACK  = 4'd6,
        EV_MR_DATA_ACK  = 4'd7,
        EV_MR_DATA_NACK = 4'd8,
        EV_OTHER        = 4'd9
    } status_event_t;

    // Acknowledge control codes.
    typedef enum logic [1:0] {
        ACK_KEEP  = 2'd0,
        ACK_SET   = 2'd1,
        ACK_CLEAR = 2'd2
    } ack_ctrl_t;

    // Transaction result codes.
    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_OK   = 2'd1,
        RES_FAIL = 2'd2
    } trans_result_t;

    // One incoming request.
    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       target_addr;
        logic [1:0]       trans_kind;
        logic [LEN_W-1:0] write_len;
        logic [LEN_W-1:0] read_len;
        logic [3:0]       buf_index;
        logic [7:0]       buf_byte;
        logic [3:0]       status_event;
        logic [7:0]       rx_byte;
    } req_t;

    // One response.
    typedef struct packed {
        logic       accepted;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       start_req;
        logic       stop_req;
        logic       clear_start;
        logic [1:0] ack_ctrl;
        logic [1:0] trans_result;
        logic       rx_valid;
        logic [3:0] rx_index;
        logic [7:0] rx_data;
        logic       idle;
    } rsp_t;

    // Queued transaction descriptor.
    typedef struct packed {
        logic [7:0]       addr;
        logic [1:0]       kind;
        logic [LEN_W-1:0] wlen;
        logic [LEN_W-1:0] rlen;
    } desc_t;

    // Sequencer control states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } seq_state_t;

endpackage

// ===== hdl/imts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the descriptor queue and the write data buffer of the sequencer.
// No dependencies.
module imts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/i2c_master_transaction_sequencer_top.sv =====
// Top level of the I2C master transaction sequencer.
// Depends on imts_pkg and instantiates imts_ram for the descriptor queue and write buffer.
//
// Usage:
// Requests arrive on req_valid / req_stall / req_data. A request is a write byte
// load, a transaction submit or a controller status event. Every request gives
// exactly one response on rsp_valid / rsp_stall / rsp_data, carrying the
// controller commands, received data, transaction result and the idle flag.
// Timing: a request is accepted, the descriptor and buffer memories are read at
// the current queue head in that same cycle, and the execute state acts on the
// read data, writes back and loads the response register once that register is
// free. The registered read of the memories is the reason for the execute state;
// no new request is taken until the last one has executed.
// A new request is accepted while an earlier response still waits. If the
// response receiver stalls, the next request is held in its execute cycle until
// the response register frees, and req_stall stays high meanwhile.
// Reset empties the queue and leaves the block idle; memory contents are
// undefined until written, and no clearing pass is run.
module i2c_master_transaction_sequencer_top #(
    parameter int QUEUE_LEN = 8,
    parameter int BUF_LEN   = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  imts_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output imts_pkg::rsp_t rsp_data
);

    localparam int PTR_W     = $clog2(QUEUE_LEN);
    localparam int IDX_W     = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
    localparam int BUF_DEPTH = QUEUE_LEN * (2 ** IDX_W);
    localparam int DESC_W    = $bits(imts_pkg::desc_t);
    localparam int LEN_W     = imts_pkg::LEN_W;

    // Control state.
    imts_pkg::seq_state_t state_reg, state_next;
    logic [PTR_W-1:0]     insert_reg, insert_next;
    logic [PTR_W-1:0]     extract_reg, extract_next;
    logic                 busy_reg, busy_next;
    logic [LEN_W-1:0]     byte_pos_reg, byte_pos_next;
    logic                 rsp_valid_reg;

    // Payload registers.
    imts_pkg::req_t       item_reg;
    imts_pkg::rsp_t       rsp_data_reg;
    imts_pkg::rsp_t       result;

    // Memory ports.
    imts_pkg::desc_t      desc_rd;
    imts_pkg::desc_t      desc_wdata;
    logic                 desc_we;
    logic [PTR_W-1:0]     desc_waddr;
    logic [7:0]           buf_rd;
    logic                 buf_we;

    logic                 out_free;
    logic                 commit;
    logic [PTR_W-1:0]     ins_wrap;
    logic [PTR_W-1:0]     ext_wrap;

    // Pointer increments with wrap at the queue length.
    assign ins_wrap = (insert_reg == PTR_W'(QUEUE_LEN - 1)) ? '0 : insert_reg + PTR_W'(1);
    assign ext_wrap = (extract_reg == PTR_W'(QUEUE_LEN - 1)) ? '0 : extract_reg + PTR_W'(1);

    // The response register can take a new value when empty or being drained.
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Descriptor queue, read at the queue head.
    imts_ram #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_LEN)
    ) u_desc_ram (
        .clk     (clk),
        .wr_en   (desc_we),
        .wr_addr (desc_waddr),
        .wr_data (desc_wdata),
        .rd_addr (extract_reg),
        .rd_data (desc_rd)
    );

    // Write data buffer, one row of bytes per queue slot.
    imts_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf_ram (
        .clk     (clk),
        .wr_en   (buf_we),
        .wr_addr ({insert_reg, IDX_W'(item_reg.buf_index)}),
        .wr_data (item_reg.buf_byte),
        .rd_addr ({extract_reg, IDX_W'(byte_pos_reg)}),
        .rd_data (buf_rd)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imts_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = imts_pkg::ST_EXEC;
                end
            end
            imts_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = imts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = imts_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        req_stall = 1'b1;
        commit    = 1'b0;
        case (state_reg)
            imts_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            imts_pkg::ST_EXEC:
            begin
                commit = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Request execution on the data read from the memories.
    always_comb
    begin
        imts_pkg::desc_t d;
        logic            end_txn;
        logic [1:0]      end_res;

        d             = desc_rd;
        end_txn       = 1'b0;
        end_res       = imts_pkg::RES_NONE;
        insert_next   = insert_reg;
        extract_next  = extract_reg;
        busy_next     = busy_reg;
        byte_pos_next = byte_pos_reg;
        desc_we       = 1'b0;
        desc_waddr    = extract_reg;
        desc_wdata    = desc_rd;
        buf_we        = 1'b0;
        result        = '0;

        case (item_reg.req_type)
            imts_pkg::REQ_LOAD:
            begin
                if (32'(item_reg.buf_index) < BUF_LEN)
                begin
                    buf_we = commit;
                end
            end
            imts_pkg::REQ_SUBMIT:
            begin
                if (ins_wrap != extract_reg)
                begin
                    d.addr = item_reg.target_addr;
                    d.kind = item_reg.trans_kind;
                    d.wlen = (32'(item_reg.write_len) > BUF_LEN) ? LEN_W'(BUF_LEN)
                                                                : item_reg.write_len;
                    d.rlen = (32'(item_reg.read_len) > BUF_LEN) ? LEN_W'(BUF_LEN)
                                                               : item_reg.read_len;
                    desc_we         = commit;
                    desc_waddr      = insert_reg;
                    desc_wdata      = d;
                    insert_next     = ins_wrap;
                    result.accepted = 1'b1;
                    if (!busy_reg)
                    begin
                        busy_next        = 1'b1;
                        result.start_req = 1'b1;
                    end
                end
            end
            imts_pkg::REQ_EVENT:
            begin
                if (busy_reg)
                begin
                    case (item_reg.status_event)
                        imts_pkg::EV_START, imts_pkg::EV_RESTART:
                        begin
                            // Set the read/write bit from the transaction kind.
                            if (d.kind == imts_pkg::KIND_READ)
                            begin
                                d.addr[0] = 1'b1;
                            end
                            else if (d.kind == imts_pkg::KIND_WRITE ||
                                     d.kind == imts_pkg::KIND_WRITE_READ)
                            begin
                                d.addr[0] = 1'b0;
                            end
                            desc_we            = commit;
                            desc_wdata         = d;
                            result.tx_valid    = 1'b1;
                            result.tx_byte     = d.addr;
                            result.clear_start = 1'b1;
                            byte_pos_next      = '0;
                        end
                        imts_pkg::EV_MR_DATA_ACK:
                        begin
                            if (byte_pos_reg < d.rlen)
                            begin
                                result.rx_valid = 1'b1;
                                result.rx_index = byte_pos_reg[3:0];
                                result.rx_data  = item_reg.rx_byte;
                                byte_pos_next   = byte_pos_reg + LEN_W'(1);
                                result.ack_ctrl =
                                    (({1'b0, byte_pos_reg} + (LEN_W+1)'(2)) < {1'b0, d.rlen})
                                    ? imts_pkg::ACK_SET : imts_pkg::ACK_CLEAR;
                            end
                            else
                            begin
                                end_txn = 1'b1;
                                end_res = imts_pkg::RES_FAIL;
                            end
                        end
                        imts_pkg::EV_MR_DATA_NACK:
                        begin
                            if (byte_pos_reg < d.rlen)
                            begin
                                result.rx_valid = 1'b1;
                                result.rx_index = byte_pos_reg[3:0];
                                result.rx_data  = item_reg.rx_byte;
                            end
                            end_txn = 1'b1;
                            end_res = imts_pkg::RES_OK;
                        end
                        imts_pkg::EV_MR_SLA_ACK:
                        begin
                            result.ack_ctrl =
                                (({1'b0, byte_pos_reg} + (LEN_W+1)'(1)) < {1'b0, d.rlen})
                                ? imts_pkg::ACK_SET : imts_pkg::ACK_CLEAR;
                        end
                        imts_pkg::EV_MT_SLA_ACK, imts_pkg::EV_MT_DATA_ACK:
                        begin
                            if (byte_pos_reg < d.wlen)
                            begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = buf_rd;
                                byte_pos_next   = byte_pos_reg + LEN_W'(1);
                            end
                            else if (d.kind == imts_pkg::KIND_WRITE_READ)
                            begin
                                // Write phase done: turn into a read with a repeated start.
                                d.kind           = imts_pkg::KIND_READ;
                                d.addr[0]        = 1'b1;
                                desc_we          = commit;
                                desc_wdata       = d;
                                byte_pos_next    = '0;
                                result.start_req = 1'b1;
                            end
                            else
                            begin
                                end_txn = 1'b1;
                                end_res = imts_pkg::RES_OK;
                            end
                        end
                        default:
                        begin
                            end_txn = 1'b1;
                            end_res = imts_pkg::RES_FAIL;
                        end
                    endcase

                    // End of transaction: stop, then start the next one if queued.
                    if (end_txn)
                    begin
                        result.stop_req     = 1'b1;
                        result.trans_result = end_res;
                        extract_next        = ext_wrap;
                        if (ext_wrap == insert_reg)
                        begin
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            result.start_req = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase

        result.idle = !busy_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imts_pkg::ST_IDLE;
            insert_reg    <= '0;
            extract_reg   <= '0;
            busy_reg      <= 1'b0;
            byte_pos_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                insert_reg    <= insert_next;
                extract_reg   <= extract_next;
                busy_reg      <= busy_next;
                byte_pos_reg  <= byte_pos_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request and response payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            item_reg <= req_data;
        end
        if (commit)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef SYNTHESIS
    // The queue holds entries exactly while a transaction is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (insert_reg != extract_reg))
        else $error("busy flag disagrees with queue occupancy");

    // A request is executed in one pass and the sequencer returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> state_reg == imts_pkg::ST_IDLE && rsp_valid_reg)
        else $error("sequencer did not complete after commit");

    // A transaction result is always paired with a stop request.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.trans_result != imts_pkg::RES_NONE
        |-> rsp_data_reg.stop_req)
        else $error("transaction ended without a stop request");

    // An accepted submit leaves a transaction in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.accepted |-> !rsp_data_reg.idle)
        else $error("accepted submit reported idle");

    // Transmit and receive data are never delivered in the same response.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_data_reg.tx_valid && rsp_data_reg.rx_valid))
        else $error("transmit and receive in one response");
`endif

endmodule
